// ===== src/b64se_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package b64se_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 24;
    localparam int unsigned SEXTET_W = 6;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0]
    {
        CNT_NONE = 2'd0,
        CNT_ONE = 2'd1,
        CNT_TWO = 2'd2,
        CNT_FULL = 2'd3
    } cnt_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] word;
        cnt_t nbytes;
        logic last;
    } grp_t;

    function automatic logic [7:0] sextet_char(input logic [SEXTET_W-1:0] s);
        logic [7:0] s8;
        logic [7:0] ch;
        s8 = {2'b00, s};
        if (s8 < 8'd26)
        begin
            ch = 8'h41 + s8;
        end
        else if (s8 < 8'd52)
        begin
            ch = 8'h61 + (s8 - 8'd26);
        end
        else if (s8 < 8'd62)
        begin
            ch = 8'h30 + (s8 - 8'd52);
        end
        else if (s8 == 8'd62)
        begin
            ch = 8'h2B;
        end
        else
        begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

// ===== src/b64se_front.sv =====
// Front part: gathers incoming bytes into groups of up to three and hands each
// finished group to the queue. Depends on b64se_pkg.
module b64se_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [7:0] in_byte,
    input  logic in_last,
    output logic grp_push,
    output b64se_pkg::grp_t grp_data
);

    logic [15:0] pending_reg;
    logic [15:0] pending_next;
    b64se_pkg::cnt_t count_reg;
    b64se_pkg::cnt_t count_next;

    always_comb
    begin
        pending_next = pending_reg;
        count_next = count_reg;
        grp_push = 1'b0;
        grp_data.word = {in_byte, 16'h0000};
        grp_data.nbytes = b64se_pkg::CNT_ONE;
        grp_data.last = in_last;
        if (in_valid)
        begin
            case (count_reg)
                b64se_pkg::CNT_NONE:
                begin
                    if (in_last)
                    begin
                        grp_push = 1'b1;
                    end
                    else
                    begin
                        pending_next = {in_byte, 8'h00};
                        count_next = b64se_pkg::CNT_ONE;
                    end
                end
                b64se_pkg::CNT_ONE:
                begin
                    grp_data.word = {pending_reg[15:8], in_byte, 8'h00};
                    grp_data.nbytes = b64se_pkg::CNT_TWO;
                    if (in_last)
                    begin
                        grp_push = 1'b1;
                        pending_next = 16'h0000;
                        count_next = b64se_pkg::CNT_NONE;
                    end
                    else
                    begin
                        pending_next = {pending_reg[15:8], in_byte};
                        count_next = b64se_pkg::CNT_TWO;
                    end
                end
                default:
                begin
                    grp_data.word = {pending_reg, in_byte};
                    grp_data.nbytes = b64se_pkg::CNT_FULL;
                    grp_push = 1'b1;
                    pending_next = 16'h0000;
                    count_next = b64se_pkg::CNT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 16'h0000;
            count_reg <= b64se_pkg::CNT_NONE;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/b64se_fifo.sv =====
// Short queue of finished byte groups between the front and back parts.
// Depends on b64se_pkg for the group type.
module b64se_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  b64se_pkg::grp_t wr_data,
    output logic full,
    input  logic rd_en,
    output b64se_pkg::grp_t rd_data,
    output logic empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64se_pkg::grp_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic do_wr;
    logic do_rd;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/b64se_back.sv =====
// Back part: takes one group at a time from the queue and sends its four
// characters through an output register, one per cycle while the consumer pops. Depends on b64se_pkg.
module b64se_back
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  b64se_pkg::grp_t q_data,
    output logic q_pop,
    output logic empty,
    input  logic pop,
    output logic [7:0] out_char,
    output logic group_last,
    output logic stream_end
);

    b64se_pkg::grp_t grp_reg;
    logic grp_valid_reg;
    logic [1:0] k_reg;
    logic out_valid_reg;
    logic [7:0] char_reg;
    logic gl_reg;
    logic se_reg;
    logic adv;
    logic grp_free;
    logic [b64se_pkg::SEXTET_W-1:0] sextet;
    logic pad;
    logic [7:0] char_next;

    assign adv = !out_valid_reg || pop;
    assign grp_free = !grp_valid_reg || (adv && k_reg == 2'd3);
    assign q_pop = grp_free && !q_empty;

    always_comb
    begin
        case (k_reg)
            2'd0: sextet = grp_reg.word[23:18];
            2'd1: sextet = grp_reg.word[17:12];
            2'd2: sextet = grp_reg.word[11:6];
            default: sextet = grp_reg.word[5:0];
        endcase
        pad = (k_reg == 2'd2 && grp_reg.nbytes == b64se_pkg::CNT_ONE)
            || (k_reg == 2'd3 && grp_reg.nbytes != b64se_pkg::CNT_FULL);
        char_next = pad ? b64se_pkg::PAD_CHAR : b64se_pkg::sextet_char(sextet);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            grp_reg <= q_data;
        end
        if (adv && grp_valid_reg)
        begin
            char_reg <= char_next;
            gl_reg <= (k_reg == 2'd3);
            se_reg <= (k_reg == 2'd3) && grp_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            k_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= grp_valid_reg;
            end
            if (q_pop)
            begin
                grp_valid_reg <= 1'b1;
                k_reg <= 2'd0;
            end
            else if (grp_free)
            begin
                grp_valid_reg <= 1'b0;
                k_reg <= 2'd0;
            end
            else if (adv)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    assign empty = !out_valid_reg;
    assign out_char = char_reg;
    assign group_last = gl_reg;
    assign stream_end = se_reg;

endmodule

// ===== src/base64_stream_encoder.sv =====
// Base64 stream encoder: one byte word in per cycle while not full, one character word out per cycle while popped.
// A byte that finishes a group passes the group queue, the back group register and the output register first.
// Throughput: the back serializer gives one character per cycle while popped, four characters per group,
// so full holds input off once the queue fills; the group queue absorbs short bursts.
// Reset: rst_n clears held bytes, the queue and the back part's valid flags; character registers are not reset.
// Depends on b64se_pkg, b64se_front, b64se_fifo and b64se_back.
module base64_stream_encoder
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic [7:0] in_byte,
    input  logic in_last,
    output logic empty,
    input  logic pop,
    output logic [7:0] out_char,
    output logic group_last,
    output logic stream_end
);

    logic grp_push;
    b64se_pkg::grp_t grp_wr;
    b64se_pkg::grp_t grp_rd;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign full = q_full;

    b64se_front u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(push && !q_full),
        .in_byte(in_byte),
        .in_last(in_last),
        .grp_push(grp_push),
        .grp_data(grp_wr)
    );

    b64se_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(grp_push),
        .wr_data(grp_wr),
        .full(q_full),
        .rd_en(q_pop),
        .rd_data(grp_rd),
        .empty(q_empty)
    );

    b64se_back u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_data(grp_rd),
        .q_pop(q_pop),
        .empty(empty),
        .pop(pop),
        .out_char(out_char),
        .group_last(group_last),
        .stream_end(stream_end)
    );

endmodule
